### rtl/core/lkv_pkg.sv
// Shared types and constants for the look-at view matrix pipeline.
// Used by lkv_norm and look_at_view_matrix; depends on nothing.
package lkv_pkg;

   // result word and entry count
   localparam int DATA_W      = 32;
   localparam int IDX_W       = 4;
   localparam int NUM_ENTRIES = 16;
   localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

   // normalizer: block scale target and square root datapath
   localparam int SCALE_BITS = 30;
   localparam int SQRT_W     = 64;
   localparam int SQRT_STEPS = 32;

   // pipeline control into a normalizer
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   // status out of a normalizer
   typedef struct packed {
      logic valid;
      logic ok;
   } norm_stat_type;

endpackage

### rtl/core/look_at_view_matrix.sv
// Left-handed look-at view matrix builder, top level.
// Depends on lkv_pkg and lkv_norm.
//
// Usage:
//  - req_ channel: one transaction carries eye, target and up vectors in
//    signed fixed point with FRAC_BITS fraction bits.
//  - rsp_ channel: each request yields 16 transactions, the matrix entries
//    in row-major order; rsp_last_entry marks entry 15 and rsp_degenerate
//    is set on all 16 when the forward or right axis had zero length.
//  - Depth: set by the two normalizers between request acceptance and the
//    first entry, each with a 32-stage square root and a FRAC_BITS+1 stage
//    divider.
//  - Throughput: set by the single result port, which sends one entry per
//    cycle while rsp_ready is high. The pipeline takes a request each cycle
//    unless stalled, so up to about 2*FRAC_BITS+92 requests are in flight.
//  - Stall: when the receiver holds rsp_ready low the output buffer keeps
//    its entry and the whole pipeline freezes once a finished matrix waits
//    behind it; req_ready falls then and nothing is dropped or repeated.
//  - Reset: synchronous, clears every valid bit and the output entry counter.
module look_at_view_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_eye_x,
   input  logic [31:0] req_eye_y,
   input  logic [31:0] req_eye_z,
   input  logic [31:0] req_target_x,
   input  logic [31:0] req_target_y,
   input  logic [31:0] req_target_z,
   input  logic [31:0] req_up_x,
   input  logic [31:0] req_up_y,
   input  logic [31:0] req_up_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_entry_index,
   output logic [31:0] rsp_matrix_value,
   output logic        rsp_last_entry,
   output logic        rsp_degenerate
);

   localparam int DW_  = lkv_pkg::DATA_W;
   localparam int AW   = FRAC_BITS + 2;
   localparam int MW   = DW_ + AW;
   localparam int CRW  = MW + 1;
   localparam int PW   = 2 * AW;
   localparam int XW   = PW + 1;
   localparam int TW   = XW - FRAC_BITS + 1;
   localparam int PRW  = TW + DW_;
   localparam int SW   = PRW + 2;
   localparam int RW   = SW - FRAC_BITS + 1;
   localparam int S1_W = 6 * DW_;
   localparam int S2_W = 3 * AW + 3 * DW_ + 1;

   logic en;
   logic load;

   // input stage: capture vectors, form target minus eye
   logic                  i_v_ff;
   logic [2:0][DW_-1:0]   i_eye_ff;
   logic [2:0][DW_-1:0]   i_up_ff;
   logic [2:0][DW_:0]     i_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_v_ff <= 1'b0;
      end else if (en) begin
         i_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i_eye_ff  <= {req_eye_z, req_eye_y, req_eye_x};
         i_up_ff   <= {req_up_z, req_up_y, req_up_x};
         i_d_ff[0] <= {req_target_x[31], req_target_x} - {req_eye_x[31], req_eye_x};
         i_d_ff[1] <= {req_target_y[31], req_target_y} - {req_eye_y[31], req_eye_y};
         i_d_ff[2] <= {req_target_z[31], req_target_z} - {req_eye_z[31], req_eye_z};
      end
   end

   // forward axis
   lkv_pkg::pipe_ctl_type  n1_ctl;
   lkv_pkg::norm_stat_type n1_stat;
   logic [2:0][AW-1:0]     n1_fw;
   logic [S1_W-1:0]        n1_side;

   assign n1_ctl.advance = en;
   assign n1_ctl.valid   = i_v_ff;

   lkv_norm #(
      .IN_W(DW_ + 1),
      .SIDE_W(S1_W),
      .FRAC_BITS(FRAC_BITS)
   ) u_norm_fw (
      .clock(clock),
      .reset(reset),
      .in_ctl(n1_ctl),
      .in_vec(i_d_ff),
      .in_side({i_up_ff, i_eye_ff}),
      .out_stat(n1_stat),
      .out_vec(n1_fw),
      .out_side(n1_side)
   );

   // cross stage 1: products of up and forward
   logic                  c1_v_ff;
   logic [5:0][MW-1:0]    c1_p_ff;
   logic [2:0][DW_-1:0]   c1_eye_ff;
   logic [2:0][AW-1:0]    c1_fw_ff;
   logic                  c1_okf_ff;
   logic [2:0][DW_-1:0]   n1_eye;
   logic [2:0][DW_-1:0]   n1_up;
   logic signed [MW-1:0]  c1_p_in [0:5];

   assign n1_eye = n1_side[3*DW_-1:0];
   assign n1_up  = n1_side[6*DW_-1:3*DW_];

   always_comb begin
      c1_p_in[0] = $signed(n1_up[1]) * $signed(n1_fw[2]);
      c1_p_in[1] = $signed(n1_up[2]) * $signed(n1_fw[1]);
      c1_p_in[2] = $signed(n1_up[2]) * $signed(n1_fw[0]);
      c1_p_in[3] = $signed(n1_up[0]) * $signed(n1_fw[2]);
      c1_p_in[4] = $signed(n1_up[0]) * $signed(n1_fw[1]);
      c1_p_in[5] = $signed(n1_up[1]) * $signed(n1_fw[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff <= 1'b0;
      end else if (en) begin
         c1_v_ff <= n1_stat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            c1_p_ff[i] <= c1_p_in[i];
         end
         c1_eye_ff <= n1_eye;
         c1_fw_ff  <= n1_fw;
         c1_okf_ff <= n1_stat.ok;
      end
   end

   // cross stage 2: differences
   logic                  c2_v_ff;
   logic [2:0][CRW-1:0]   c2_cr_ff;
   logic [2:0][DW_-1:0]   c2_eye_ff;
   logic [2:0][AW-1:0]    c2_fw_ff;
   logic                  c2_okf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_v_ff <= 1'b0;
      end else if (en) begin
         c2_v_ff <= c1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c2_cr_ff[i] <= {c1_p_ff[2*i][MW-1], c1_p_ff[2*i]}
                         - {c1_p_ff[2*i+1][MW-1], c1_p_ff[2*i+1]};
         end
         c2_eye_ff <= c1_eye_ff;
         c2_fw_ff  <= c1_fw_ff;
         c2_okf_ff <= c1_okf_ff;
      end
   end

   // right axis
   lkv_pkg::pipe_ctl_type  n2_ctl;
   lkv_pkg::norm_stat_type n2_stat;
   logic [2:0][AW-1:0]     n2_rt;
   logic [S2_W-1:0]        n2_side;

   assign n2_ctl.advance = en;
   assign n2_ctl.valid   = c2_v_ff;

   lkv_norm #(
      .IN_W(CRW),
      .SIDE_W(S2_W),
      .FRAC_BITS(FRAC_BITS)
   ) u_norm_rt (
      .clock(clock),
      .reset(reset),
      .in_ctl(n2_ctl),
      .in_vec(c2_cr_ff),
      .in_side({c2_fw_ff, c2_eye_ff, c2_okf_ff}),
      .out_stat(n2_stat),
      .out_vec(n2_rt),
      .out_side(n2_side)
   );

   logic [2:0][AW-1:0]  n2_fw;
   logic [2:0][DW_-1:0] n2_eye;
   logic                n2_okf;

   assign n2_okf = n2_side[0];
   assign n2_eye = n2_side[3*DW_:1];
   assign n2_fw  = n2_side[S2_W-1:3*DW_+1];

   // true up stage 1: products of forward and right
   logic                  t1_v_ff;
   logic [5:0][PW-1:0]    t1_p_ff;
   logic [2:0][AW-1:0]    t1_rt_ff;
   logic [2:0][AW-1:0]    t1_fw_ff;
   logic [2:0][DW_-1:0]   t1_eye_ff;
   logic                  t1_deg_ff;
   logic signed [PW-1:0]  t1_p_in [0:5];

   always_comb begin
      t1_p_in[0] = $signed(n2_fw[1]) * $signed(n2_rt[2]);
      t1_p_in[1] = $signed(n2_fw[2]) * $signed(n2_rt[1]);
      t1_p_in[2] = $signed(n2_fw[2]) * $signed(n2_rt[0]);
      t1_p_in[3] = $signed(n2_fw[0]) * $signed(n2_rt[2]);
      t1_p_in[4] = $signed(n2_fw[0]) * $signed(n2_rt[1]);
      t1_p_in[5] = $signed(n2_fw[1]) * $signed(n2_rt[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
      end else if (en) begin
         t1_v_ff <= n2_stat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            t1_p_ff[i] <= t1_p_in[i];
         end
         t1_rt_ff  <= n2_rt;
         t1_fw_ff  <= n2_fw;
         t1_eye_ff <= n2_eye;
         t1_deg_ff <= ~(n2_okf & n2_stat.ok);
      end
   end

   // true up stage 2: differences
   logic                  t2_v_ff;
   logic [2:0][XW-1:0]    t2_x_ff;
   logic [2:0][AW-1:0]    t2_rt_ff;
   logic [2:0][AW-1:0]    t2_fw_ff;
   logic [2:0][DW_-1:0]   t2_eye_ff;
   logic                  t2_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_v_ff <= 1'b0;
      end else if (en) begin
         t2_v_ff <= t1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            t2_x_ff[i] <= {t1_p_ff[2*i][PW-1], t1_p_ff[2*i]}
                        - {t1_p_ff[2*i+1][PW-1], t1_p_ff[2*i+1]};
         end
         t2_rt_ff  <= t1_rt_ff;
         t2_fw_ff  <= t1_fw_ff;
         t2_eye_ff <= t1_eye_ff;
         t2_deg_ff <= t1_deg_ff;
      end
   end

   // true up stage 3: round half away from zero
   logic                  t3_v_ff;
   logic [2:0][TW-1:0]    t3_tu_ff;
   logic [2:0][AW-1:0]    t3_rt_ff;
   logic [2:0][AW-1:0]    t3_fw_ff;
   logic [2:0][DW_-1:0]   t3_eye_ff;
   logic                  t3_deg_ff;
   logic [2:0][TW-1:0]    t3_tu_in;

   always_comb begin
      logic [XW-1:0] mag;
      logic [XW-1:0] rnd;
      logic [TW-1:0] r;
      for (int i = 0; i < 3; i++) begin
         mag = t2_x_ff[i][XW-1] ? (~t2_x_ff[i] + 1'b1) : t2_x_ff[i];
         rnd = (mag + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         r   = {1'b0, rnd[TW-2:0]};
         t3_tu_in[i] = t2_x_ff[i][XW-1] ? (~r + 1'b1) : r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_v_ff <= 1'b0;
      end else if (en) begin
         t3_v_ff <= t2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_tu_ff  <= t3_tu_in;
         t3_rt_ff  <= t2_rt_ff;
         t3_fw_ff  <= t2_fw_ff;
         t3_eye_ff <= t2_eye_ff;
         t3_deg_ff <= t2_deg_ff;
      end
   end

   // translation stage 1: axis times eye products
   logic                      t4_v_ff;
   logic [2:0][2:0][PRW-1:0]  t4_p_ff;
   logic [2:0][AW-1:0]        t4_rt_ff;
   logic [2:0][TW-1:0]        t4_tu_ff;
   logic [2:0][AW-1:0]        t4_fw_ff;
   logic                      t4_deg_ff;
   logic signed [PRW-1:0]     t4_p_in [0:2][0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         t4_p_in[0][c] = $signed(t3_rt_ff[c]) * $signed(t3_eye_ff[c]);
         t4_p_in[1][c] = $signed(t3_tu_ff[c]) * $signed(t3_eye_ff[c]);
         t4_p_in[2][c] = $signed(t3_fw_ff[c]) * $signed(t3_eye_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_v_ff <= 1'b0;
      end else if (en) begin
         t4_v_ff <= t3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
               t4_p_ff[a][c] <= t4_p_in[a][c];
            end
         end
         t4_rt_ff  <= t3_rt_ff;
         t4_tu_ff  <= t3_tu_ff;
         t4_fw_ff  <= t3_fw_ff;
         t4_deg_ff <= t3_deg_ff;
      end
   end

   // translation stage 2: dot product sums
   logic                  t5_v_ff;
   logic [2:0][SW-1:0]    t5_s_ff;
   logic [2:0][AW-1:0]    t5_rt_ff;
   logic [2:0][TW-1:0]    t5_tu_ff;
   logic [2:0][AW-1:0]    t5_fw_ff;
   logic                  t5_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t5_v_ff <= 1'b0;
      end else if (en) begin
         t5_v_ff <= t4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            t5_s_ff[a] <= {{2{t4_p_ff[a][0][PRW-1]}}, t4_p_ff[a][0]}
                        + {{2{t4_p_ff[a][1][PRW-1]}}, t4_p_ff[a][1]}
                        + {{2{t4_p_ff[a][2][PRW-1]}}, t4_p_ff[a][2]};
         end
         t5_rt_ff  <= t4_rt_ff;
         t5_tu_ff  <= t4_tu_ff;
         t5_fw_ff  <= t4_fw_ff;
         t5_deg_ff <= t4_deg_ff;
      end
   end

   // translation stage 3: rescale, negate, saturate
   logic                  t6_v_ff;
   logic [2:0][DW_-1:0]   t6_tr_ff;
   logic [2:0][AW-1:0]    t6_rt_ff;
   logic [2:0][TW-1:0]    t6_tu_ff;
   logic [2:0][AW-1:0]    t6_fw_ff;
   logic                  t6_deg_ff;
   logic [2:0][DW_-1:0]   t6_tr_in;

   always_comb begin
      logic [SW-1:0] mag;
      logic [SW-1:0] rnd;
      logic [RW-1:0] r;
      logic [RW-1:0] t;
      for (int a = 0; a < 3; a++) begin
         mag = t5_s_ff[a][SW-1] ? (~t5_s_ff[a] + 1'b1) : t5_s_ff[a];
         rnd = (mag + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         r   = {1'b0, rnd[RW-2:0]};
         t   = t5_s_ff[a][SW-1] ? r : (~r + 1'b1);
         if (t[RW-1:DW_-1] == '0 || t[RW-1:DW_-1] == '1) begin
            t6_tr_in[a] = t[DW_-1:0];
         end else if (t[RW-1]) begin
            t6_tr_in[a] = {1'b1, {(DW_-1){1'b0}}};
         end else begin
            t6_tr_in[a] = {1'b0, {(DW_-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t6_v_ff <= 1'b0;
      end else if (en) begin
         t6_v_ff <= t5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t6_tr_ff  <= t6_tr_in;
         t6_rt_ff  <= t5_rt_ff;
         t6_tu_ff  <= t5_tu_ff;
         t6_fw_ff  <= t5_fw_ff;
         t6_deg_ff <= t5_deg_ff;
      end
   end

   // output buffer: one matrix, sent one entry per transaction
   logic                          hold_v_ff;
   logic [lkv_pkg::IDX_W-1:0]     cnt_ff;
   logic [DW_-1:0]                mat_ff [0:lkv_pkg::NUM_ENTRIES-1];
   logic                          deg_ff;
   logic                          last_out;

   assign last_out = (cnt_ff == lkv_pkg::LAST_IDX);
   assign load     = t6_v_ff & (~hold_v_ff | (rsp_ready & last_out));
   assign en       = ~t6_v_ff | load;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         cnt_ff    <= '0;
      end else if (load) begin
         hold_v_ff <= 1'b1;
         cnt_ff    <= '0;
      end else if (hold_v_ff && rsp_ready) begin
         if (last_out) begin
            hold_v_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // fill the matrix rows on load
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            mat_ff[i*4+0] <= {{(DW_-AW){t6_rt_ff[i][AW-1]}}, t6_rt_ff[i]};
            mat_ff[i*4+1] <= {{(DW_-TW){t6_tu_ff[i][TW-1]}}, t6_tu_ff[i]};
            mat_ff[i*4+2] <= {{(DW_-AW){t6_fw_ff[i][AW-1]}}, t6_fw_ff[i]};
            mat_ff[i*4+3] <= '0;
         end
         mat_ff[12] <= t6_tr_ff[0];
         mat_ff[13] <= t6_tr_ff[1];
         mat_ff[14] <= t6_tr_ff[2];
         mat_ff[15] <= DW_'(1) << FRAC_BITS;
         deg_ff     <= t6_deg_ff;
      end
   end

   assign req_ready        = en;
   assign rsp_valid        = hold_v_ff;
   assign rsp_entry_index  = cnt_ff;
   assign rsp_matrix_value = mat_ff[cnt_ff];
   assign rsp_last_entry   = last_out;
   assign rsp_degenerate   = deg_ff;

endmodule

### rtl/core/lkv_norm.sv
// Pipelined 3-vector normalizer: block scale, sum of squares, bit-per-stage
// square root and bit-per-stage division for each lane. Uses lkv_pkg.
module lkv_norm #(
   parameter int IN_W = 33,
   parameter int SIDE_W = 1,
   parameter int FRAC_BITS = 16,
   localparam int AXIS_W = FRAC_BITS + 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  lkv_pkg::pipe_ctl_type      in_ctl,
   input  logic [2:0][IN_W-1:0]       in_vec,
   input  logic [SIDE_W-1:0]          in_side,
   output lkv_pkg::norm_stat_type     out_stat,
   output logic [2:0][AXIS_W-1:0]     out_vec,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int SC    = lkv_pkg::SCALE_BITS;
   localparam int SQ_W  = lkv_pkg::SQRT_W;
   localparam int STEPS = lkv_pkg::SQRT_STEPS;
   localparam int BL_W  = $clog2(IN_W + 1);
   localparam int LEN_W = SC + 1;
   localparam int NUM_W = SC + FRAC_BITS + 1;
   localparam int Q_W   = FRAC_BITS + 1;

   logic adv;
   assign adv = in_ctl.advance;

   // stage a: magnitudes and signs
   logic                  a_v_ff;
   logic [2:0][IN_W-1:0]  a_mag_ff;
   logic [2:0]            a_neg_ff;
   logic [SIDE_W-1:0]     a_side_ff;
   logic [2:0][IN_W-1:0]  a_mag_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff  <= a_mag_in;
         for (int i = 0; i < 3; i++) begin
            a_neg_ff[i] <= in_vec[i][IN_W-1];
         end
         a_side_ff <= in_side;
      end
   end

   // stage b: largest magnitude
   logic                  b_v_ff;
   logic [IN_W-1:0]       b_top_ff;
   logic [2:0][IN_W-1:0]  b_mag_ff;
   logic [2:0]            b_neg_ff;
   logic [SIDE_W-1:0]     b_side_ff;
   logic [IN_W-1:0]       b_top_in;

   always_comb begin
      b_top_in = a_mag_ff[0];
      if (a_mag_ff[1] > b_top_in) begin
         b_top_in = a_mag_ff[1];
      end
      if (a_mag_ff[2] > b_top_in) begin
         b_top_in = a_mag_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_top_ff  <= b_top_in;
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // stage c: bit length of the largest magnitude
   logic                  c_v_ff;
   logic [BL_W-1:0]       c_bl_ff;
   logic                  c_zero_ff;
   logic [2:0][IN_W-1:0]  c_mag_ff;
   logic [2:0]            c_neg_ff;
   logic [SIDE_W-1:0]     c_side_ff;
   logic [BL_W-1:0]       c_bl_in;

   always_comb begin
      c_bl_in = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (b_top_ff[i]) begin
            c_bl_in = BL_W'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_bl_ff   <= c_bl_in;
         c_zero_ff <= (b_top_ff == '0);
         c_mag_ff  <= b_mag_ff;
         c_neg_ff  <= b_neg_ff;
         c_side_ff <= b_side_ff;
      end
   end

   // stage d: scale so the largest magnitude lands in [2^29, 2^30)
   logic                  d_v_ff;
   logic [2:0][SC-1:0]    d_m_ff;
   logic                  d_zero_ff;
   logic [2:0]            d_neg_ff;
   logic [SIDE_W-1:0]     d_side_ff;
   logic [2:0][SC-1:0]    d_m_in;

   always_comb begin
      logic [IN_W+SC-1:0] wide;
      for (int i = 0; i < 3; i++) begin
         wide      = {c_mag_ff[i], {SC{1'b0}}} >> c_bl_ff;
         d_m_in[i] = wide[SC-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (adv) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_m_ff    <= d_m_in;
         d_zero_ff <= c_zero_ff;
         d_neg_ff  <= c_neg_ff;
         d_side_ff <= c_side_ff;
      end
   end

   // stage e: squares
   logic                    e_v_ff;
   logic [2:0][2*SC-1:0]    e_sq_ff;
   logic [2:0][SC-1:0]      e_m_ff;
   logic                    e_zero_ff;
   logic [2:0]              e_neg_ff;
   logic [SIDE_W-1:0]       e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e_sq_ff[i] <= d_m_ff[i] * d_m_ff[i];
         end
         e_m_ff    <= d_m_ff;
         e_zero_ff <= d_zero_ff;
         e_neg_ff  <= d_neg_ff;
         e_side_ff <= d_side_ff;
      end
   end

   // square root pipeline, entry 0 loaded with the sum of squares
   logic                  s_v_ff    [0:STEPS];
   logic [SQ_W-1:0]       s_x_ff    [0:STEPS];
   logic [SQ_W-1:0]       s_res_ff  [0:STEPS];
   logic [2:0][SC-1:0]    s_m_ff    [0:STEPS];
   logic                  s_zero_ff [0:STEPS];
   logic [2:0]            s_neg_ff  [0:STEPS];
   logic [SIDE_W-1:0]     s_side_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff[0] <= 1'b0;
      end else if (adv) begin
         s_v_ff[0] <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_x_ff[0]    <= SQ_W'(e_sq_ff[0]) + SQ_W'(e_sq_ff[1]) + SQ_W'(e_sq_ff[2]);
         s_res_ff[0]  <= '0;
         s_m_ff[0]    <= e_m_ff;
         s_zero_ff[0] <= e_zero_ff;
         s_neg_ff[0]  <= e_neg_ff;
         s_side_ff[0] <= e_side_ff;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (STEPS - 1 - k));
      logic [SQ_W-1:0] x_in;
      logic [SQ_W-1:0] res_in;
      logic [SQ_W-1:0] trial;

      // one root bit per stage
      always_comb begin
         trial = s_res_ff[k] + BIT;
         if (s_x_ff[k] >= trial) begin
            x_in   = s_x_ff[k] - trial;
            res_in = (s_res_ff[k] >> 1) + BIT;
         end else begin
            x_in   = s_x_ff[k];
            res_in = s_res_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            s_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            s_v_ff[k+1] <= s_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s_x_ff[k+1]    <= x_in;
            s_res_ff[k+1]  <= res_in;
            s_m_ff[k+1]    <= s_m_ff[k];
            s_zero_ff[k+1] <= s_zero_ff[k];
            s_neg_ff[k+1]  <= s_neg_ff[k];
            s_side_ff[k+1] <= s_side_ff[k];
         end
      end
   end

   // division pipeline, entry 0 loaded with the rounded numerators
   logic                   dv_v_ff    [0:Q_W];
   logic [2:0][NUM_W-1:0]  dv_rem_ff  [0:Q_W];
   logic [2:0][Q_W-1:0]    dv_q_ff    [0:Q_W];
   logic [LEN_W-1:0]       dv_len_ff  [0:Q_W];
   logic                   dv_zero_ff [0:Q_W];
   logic [2:0]             dv_neg_ff  [0:Q_W];
   logic [SIDE_W-1:0]      dv_side_ff [0:Q_W];
   logic [LEN_W-1:0]       len_in;
   logic [2:0][NUM_W-1:0]  num_in;

   always_comb begin
      len_in = s_res_ff[STEPS][LEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUM_W'(s_m_ff[STEPS][i]) << FRAC_BITS) + NUM_W'(len_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= s_v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0]  <= num_in;
         dv_q_ff[0]    <= '0;
         dv_len_ff[0]  <= len_in;
         dv_zero_ff[0] <= s_zero_ff[STEPS];
         dv_neg_ff[0]  <= s_neg_ff[STEPS];
         dv_side_ff[0] <= s_side_ff[STEPS];
      end
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      localparam int SH = Q_W - 1 - j;
      logic [2:0][NUM_W-1:0] rem_in;
      logic [2:0][Q_W-1:0]   q_in;
      logic [NUM_W-1:0]      dd;

      // one quotient bit per stage in each lane
      always_comb begin
         dd = NUM_W'(dv_len_ff[j]) << SH;
         rem_in = dv_rem_ff[j];
         q_in   = dv_q_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[j][i] >= dd) begin
               rem_in[i]   = dv_rem_ff[j][i] - dd;
               q_in[i][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j+1]  <= rem_in;
            dv_q_ff[j+1]    <= q_in;
            dv_len_ff[j+1]  <= dv_len_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   // output: apply signs, zero the axis when its length is zero
   logic                   o_v_ff;
   logic                   o_ok_ff;
   logic [2:0][AXIS_W-1:0] o_vec_ff;
   logic [SIDE_W-1:0]      o_side_ff;
   logic [2:0][AXIS_W-1:0] o_vec_in;

   always_comb begin
      logic [AXIS_W-1:0] mag;
      for (int i = 0; i < 3; i++) begin
         mag = {1'b0, dv_q_ff[Q_W][i]};
         if (dv_zero_ff[Q_W]) begin
            o_vec_in[i] = '0;
         end else if (dv_neg_ff[Q_W][i]) begin
            o_vec_in[i] = ~mag + 1'b1;
         end else begin
            o_vec_in[i] = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (adv) begin
         o_v_ff <= dv_v_ff[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_ok_ff   <= ~dv_zero_ff[Q_W];
         o_vec_ff  <= o_vec_in;
         o_side_ff <= dv_side_ff[Q_W];
      end
   end

   assign out_stat.valid = o_v_ff;
   assign out_stat.ok    = o_ok_ff;
   assign out_vec        = o_vec_ff;
   assign out_side       = o_side_ff;

endmodule

### verif/tb_top.sv
// Self-checking testbench for look_at_view_matrix: drives eye/target/up
// requests and checks all 16 matrix entries against an in-bench predictor.
// Depends on lkv_pkg and the look_at_view_matrix RTL.
module tb_top;

   localparam int FRAC      = 16;
   localparam int MAX_SHOW  = 10;
   localparam int DRAIN_CYC = 2 * FRAC + 200;

   typedef struct {
      logic [lkv_pkg::IDX_W-1:0]  idx;
      logic [lkv_pkg::DATA_W-1:0] value;
      logic                       last;
      logic                       degen;
   } entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic [31:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_entry_index;
   logic [31:0] rsp_matrix_value;
   logic        rsp_last_entry;
   logic        rsp_degenerate;

   entry_type pending_entries[$];
   int        mismatch_count = 0;
   int        send_idle_pct  = 0;
   int        recv_idle_pct  = 0;
   int        hold_len       = 0;

   look_at_view_matrix #(.FRAC_BITS(FRAC)) dut (.*);

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned res, bits;
      res  = 0;
      bits = 64'd1 << 62;
      while (bits > x) bits = bits >> 2;
      while (bits != 0) begin
         if (x >= res + bits) begin
            x   = x - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // round half away from zero, drop FRAC fraction bits
   function automatic longint drop_frac(input longint v);
      longint unsigned m;
      m = (magnitude(v) + (64'd1 << (FRAC - 1))) >> FRAC;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // normalize a vector; zero length gives a zero axis and returns 0
   function automatic bit unit_axis(input longint v[3], output longint r[3]);
      longint unsigned m[3];
      longint unsigned top, sum, len, q;
      int bits;
      top = 0;
      sum = 0;
      bits = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = magnitude(v[i]);
         if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
         for (int i = 0; i < 3; i++) r[i] = 0;
         return 1'b0;
      end
      while (bits < 63 && (top >> bits) != 0) bits++;
      for (int i = 0; i < 3; i++) begin
         if (bits < lkv_pkg::SCALE_BITS) m[i] = m[i] << (lkv_pkg::SCALE_BITS - bits);
         else m[i] = m[i] >> (bits - lkv_pkg::SCALE_BITS);
         sum += m[i] * m[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC) + (len >> 1)) / len;
         r[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic longint dot_eye(input longint a[3], input longint e[3]);
      return clamp32(-drop_frac(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]));
   endfunction

   // build the expected view matrix and queue its 16 entries
   function automatic void queue_view_matrix(input logic [31:0] eye_w[3],
                                             input logic [31:0] tgt_w[3],
                                             input logic [31:0] up_w[3]);
      longint eye[3], dir[3], up[3], fwd[3], crs[3], rgt[3], tup[3], mat[16];
      bit fwd_ok, rgt_ok;
      entry_type ent;
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'(signed'(eye_w[i]));
         dir[i] = longint'(signed'(tgt_w[i])) - eye[i];
         up[i]  = longint'(signed'(up_w[i]));
      end
      fwd_ok = unit_axis(dir, fwd);
      crs[0] = up[1] * fwd[2] - up[2] * fwd[1];
      crs[1] = up[2] * fwd[0] - up[0] * fwd[2];
      crs[2] = up[0] * fwd[1] - up[1] * fwd[0];
      rgt_ok = unit_axis(crs, rgt);
      tup[0] = drop_frac(fwd[1] * rgt[2] - fwd[2] * rgt[1]);
      tup[1] = drop_frac(fwd[2] * rgt[0] - fwd[0] * rgt[2]);
      tup[2] = drop_frac(fwd[0] * rgt[1] - fwd[1] * rgt[0]);
      for (int i = 0; i < 3; i++) begin
         mat[i * 4 + 0] = rgt[i];
         mat[i * 4 + 1] = tup[i];
         mat[i * 4 + 2] = fwd[i];
         mat[i * 4 + 3] = 0;
      end
      mat[12] = dot_eye(rgt, eye);
      mat[13] = dot_eye(tup, eye);
      mat[14] = dot_eye(fwd, eye);
      mat[15] = longint'(1) << FRAC;
      for (int k = 0; k < lkv_pkg::NUM_ENTRIES; k++) begin
         ent.idx   = k[lkv_pkg::IDX_W-1:0];
         ent.value = mat[k][31:0];
         ent.last  = (k[lkv_pkg::IDX_W-1:0] == lkv_pkg::LAST_IDX);
         ent.degen = !(fwd_ok && rgt_ok);
         pending_entries.push_back(ent);
      end
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   task automatic send_view(input logic [31:0] ex, ey, ez, tx, ty, tz,
                            input logic [31:0] ux, uy, uz);
      logic [31:0] eye_w[3], tgt_w[3], up_w[3];
      eye_w = '{ex, ey, ez};
      tgt_w = '{tx, ty, tz};
      up_w  = '{ux, uy, uz};
      @(negedge clock);
      // idle the request channel for a random gap
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_eye_x <= ex;  req_eye_y <= ey;  req_eye_z <= ez;
      req_target_x <= tx;  req_target_y <= ty;  req_target_z <= tz;
      req_up_x <= ux;  req_up_y <= uy;  req_up_z <= uz;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queue_view_matrix(eye_w, tgt_w, up_w);
   endtask

   // small signed values around the origin, sometimes full range
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) << FRAC;
         2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
         default: return 32'($signed($urandom_range(200)) - 100) << 12;
      endcase
   endfunction

   task automatic send_random_view();
      logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
      ex = pick_coord(); ey = pick_coord(); ez = pick_coord();
      tx = pick_coord(); ty = pick_coord(); tz = pick_coord();
      ux = pick_coord(); uy = pick_coord(); uz = pick_coord();
      // occasionally force a degenerate camera
      case ($urandom_range(19))
         0: begin tx = ex; ty = ey; tz = ez; end
         1: begin ux = tx - ex; uy = ty - ey; uz = tz - ez; end
         2: begin ux = '0; uy = '0; uz = '0; end
         default: ;
      endcase
      send_view(ex, ey, ez, tx, ty, tz, ux, uy, uz);
   endtask

   // ---------------------------------------------------------------------
   // response side: ready generator and checker
   // ---------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      entry_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_entries.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOW)
               $display("unexpected entry idx=%0d value=%h", rsp_entry_index,
                        rsp_matrix_value);
         end else begin
            want = pending_entries.pop_front();
            if (rsp_entry_index !== want.idx || rsp_matrix_value !== want.value ||
                rsp_last_entry !== want.last || rsp_degenerate !== want.degen) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOW)
                  $display({"entry mismatch: exp idx=%0d val=%h last=%b degen=%b,",
                            " got idx=%0d val=%h last=%b degen=%b"},
                           want.idx, want.value, want.last, want.degen,
                           rsp_entry_index, rsp_matrix_value, rsp_last_entry,
                           rsp_degenerate);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   localparam logic [31:0] ONE  = 32'h0001_0000;
   localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] MINV = 32'h8000_0000;

   task automatic test_extremes();
      send_view(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV);
      send_view(MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MINV);
      send_view(MINV, MAXV, '0, MAXV, MINV, ONE, '1, MAXV, 32'h1);
      send_view('0, '0, '0, '0, '0, ONE, '0, ONE, '0);
      send_view('0, '0, '0, ONE, '0, '0, '0, ONE, '0);
      send_view(32'h1, 32'h1, 32'h1, 32'h2, 32'h1, 32'h1, '0, '0, 32'h1);
      send_view(ONE * 5, -ONE * 3, ONE * 7, -ONE, ONE * 2, ONE * 9,
                '0, ONE, '0);
      send_view(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0,
                32'hFFFF_0000, 32'h0000_FFFF, 32'h1234_5678);
   endtask

   task automatic test_degenerate();
      // eye equals target, so forward has no length
      send_view(ONE, ONE * 2, ONE * 3, ONE, ONE * 2, ONE * 3, '0, ONE, '0);
      send_view(MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV);
      // zero up vector
      send_view('0, '0, '0, ONE, ONE, ONE, '0, '0, '0);
      // up parallel and antiparallel to forward
      send_view('0, '0, '0, '0, ONE, '0, '0, ONE * 4, '0);
      send_view('0, '0, '0, ONE, ONE, '0, -ONE, -ONE, '0);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_random_view();
   endtask

   task automatic test_backpressure();
      // hold the receiver off long enough that finished matrices back up and stall the pipeline
      @(negedge clock);
      req_valid <= 1'b0;
      hold_len = 600;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (60) send_random_view();
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      @(negedge reset);
      test_extremes();
      test_degenerate();
      send_idle_pct = 27; recv_idle_pct = 64;
      test_random(110);
      send_idle_pct = 64; recv_idle_pct = 27;
      test_random(110);
      send_idle_pct = 0;  recv_idle_pct = 0;
      test_random(110);
      test_backpressure();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatch_count == 0)
         $display("look_at_view_matrix verification clean");
      else
         $display("look_at_view_matrix verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("look_at_view_matrix verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/core/lkv_pkg.sv
rtl/core/lkv_norm.sv
rtl/core/look_at_view_matrix.sv
verif/tb_top.sv
